// ===== rtl/cwas_pkg.sv =====
// ----------------------------------------------------------------------------
// cwas_pkg: shared constants for the checked wide add/sub/multiply unit
// Limb sizes, operand widths and operation codes.
// ----------------------------------------------------------------------------
package cwas_pkg;

    localparam int LIMB_COUNT = 4;
    localparam int LIMB_W     = 64;
    localparam int HALF_W     = 32;
    localparam int OPND_W     = LIMB_COUNT * LIMB_W;
    localparam int PROD_W     = 2 * OPND_W;

    typedef logic [LIMB_W-1:0] limb_t;
    typedef logic [HALF_W-1:0] half_t;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

endpackage

// ===== rtl/checked_wide_add_sub_mul.sv =====
// ----------------------------------------------------------------------------
// checked_wide_add_sub_mul: checked 256-bit add, subtract and multiply
// A word is taken on every cycle with start high; busy never rises. Each
// word gives one result with done high for exactly one cycle, after the
// two register stages in each of the four limb cells and the output
// register; the receiver cannot stall, so results must be taken as they
// come. Add and subtract clear ok on a carry or borrow out of the top limb;
// multiply gives the low half with ok set when the high half is zero, else
// zero with ok clear. Mode three gives zero with ok clear.
// ----------------------------------------------------------------------------
module checked_wide_add_sub_mul
    import cwas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [63:0] a_limb0,
    input  logic [63:0] a_limb1,
    input  logic [63:0] a_limb2,
    input  logic [63:0] a_limb3,
    input  logic [63:0] b_limb0,
    input  logic [63:0] b_limb1,
    input  logic [63:0] b_limb2,
    input  logic [63:0] b_limb3,
    output logic        done,
    output logic [63:0] sum_limb0,
    output logic [63:0] sum_limb1,
    output logic [63:0] sum_limb2,
    output logic [63:0] sum_limb3,
    output logic        ok
);

    logic              v   [LIMB_COUNT+1];
    logic [1:0]        md  [LIMB_COUNT+1];
    logic [OPND_W-1:0] av  [LIMB_COUNT+1];
    logic [OPND_W-1:0] bv  [LIMB_COUNT+1];
    logic [PROD_W-1:0] acc [LIMB_COUNT+1];
    logic              cy  [LIMB_COUNT+1];
    logic [OPND_W-1:0] rs  [LIMB_COUNT+1];

    logic              done_reg;
    logic [OPND_W-1:0] sum_reg;
    logic              ok_reg;
    logic [OPND_W-1:0] sum_next;
    logic              ok_next;
    logic              upper_zero;

    assign busy  = 1'b0;
    assign v[0]  = start;
    assign md[0] = mode;
    assign av[0] = {a_limb3, a_limb2, a_limb1, a_limb0};
    assign bv[0] = {b_limb3, b_limb2, b_limb1, b_limb0};
    assign acc[0] = '0;
    assign cy[0]  = 1'b0;
    assign rs[0]  = '0;

    // Chain of limb cells, least significant first
    for (genvar k = 0; k < LIMB_COUNT; k++)
    begin : g_cell
        cwas_cell #(.IDX(k)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v[k]),
            .in_mode  (md[k]),
            .in_a     (av[k]),
            .in_b     (bv[k]),
            .in_acc   (acc[k]),
            .in_carry (cy[k]),
            .in_res   (rs[k]),
            .out_valid(v[k+1]),
            .out_mode (md[k+1]),
            .out_a    (av[k+1]),
            .out_b    (bv[k+1]),
            .out_acc  (acc[k+1]),
            .out_carry(cy[k+1]),
            .out_res  (rs[k+1])
        );
    end

    // Pick the result and check for overflow
    always_comb
    begin
        upper_zero = (acc[LIMB_COUNT][PROD_W-1:OPND_W] == '0);
        case (md[LIMB_COUNT])
            MODE_ADD, MODE_SUB:
            begin
                sum_next = rs[LIMB_COUNT];
                ok_next  = !cy[LIMB_COUNT];
            end
            MODE_MUL:
            begin
                sum_next = upper_zero ? acc[LIMB_COUNT][OPND_W-1:0] : '0;
                ok_next  = upper_zero;
            end
            default:
            begin
                sum_next = '0;
                ok_next  = 1'b0;
            end
        endcase
    end

    // Strobe the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v[LIMB_COUNT];
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        ok_reg  <= ok_next;
    end

    assign done      = done_reg;
    assign sum_limb0 = sum_reg[0*LIMB_W +: LIMB_W];
    assign sum_limb1 = sum_reg[1*LIMB_W +: LIMB_W];
    assign sum_limb2 = sum_reg[2*LIMB_W +: LIMB_W];
    assign sum_limb3 = sum_reg[3*LIMB_W +: LIMB_W];
    assign ok        = ok_reg;

endmodule

// ===== rtl/cwas_cell.sv =====
// ----------------------------------------------------------------------------
// cwas_cell: one limb cell of the operand pipeline
// Adds or subtracts limb IDX with the carry from the cell below and adds
// row IDX of the schoolbook product into the running accumulator. Two
// register stages: 32x32 partial products, then the row sum.
// ----------------------------------------------------------------------------
module cwas_cell
    import cwas_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    input  logic [OPND_W-1:0] in_a,
    input  logic [OPND_W-1:0] in_b,
    input  logic [PROD_W-1:0] in_acc,
    input  logic              in_carry,
    input  logic [OPND_W-1:0] in_res,
    output logic              out_valid,
    output logic [1:0]        out_mode,
    output logic [OPND_W-1:0] out_a,
    output logic [OPND_W-1:0] out_b,
    output logic [PROD_W-1:0] out_acc,
    output logic              out_carry,
    output logic [OPND_W-1:0] out_res
);

    localparam int ROW_W = LIMB_W * (LIMB_COUNT + 1);

    logic              valid_reg;
    logic [1:0]        mode_reg;
    logic [OPND_W-1:0] a_reg;
    logic [OPND_W-1:0] b_reg;
    logic [PROD_W-1:0] acc_reg;
    logic              carry_reg;
    logic [OPND_W-1:0] res_reg;
    limb_t             pp_reg [LIMB_COUNT][4];

    logic              valid2_reg;
    logic [1:0]        mode2_reg;
    logic [OPND_W-1:0] a2_reg;
    logic [OPND_W-1:0] b2_reg;
    logic [PROD_W-1:0] acc2_reg;
    logic              carry2_reg;
    logic [OPND_W-1:0] res2_reg;

    limb_t             a_k;
    half_t             a_lo;
    half_t             a_hi;
    logic [OPND_W-1:0] pp_ll;
    logic [OPND_W-1:0] pp_lh;
    logic [OPND_W-1:0] pp_hl;
    logic [OPND_W-1:0] pp_hh;
    logic [ROW_W-1:0]  row;
    logic [PROD_W-1:0] acc_next;
    logic [LIMB_W:0]   limb_sum;
    logic [LIMB_W:0]   limb_dif;
    logic              carry_next;
    logic [OPND_W-1:0] res_next;

    assign a_k  = in_a[IDX*LIMB_W +: LIMB_W];
    assign a_lo = a_k[HALF_W-1:0];
    assign a_hi = a_k[LIMB_W-1:HALF_W];

    // Advance valid through both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= in_valid;
            valid2_reg <= valid_reg;
        end
    end

    // Stage one: hold the word and form the 32x32 partial products
    always_ff @(posedge clk)
    begin
        mode_reg  <= in_mode;
        a_reg     <= in_a;
        b_reg     <= in_b;
        acc_reg   <= in_acc;
        carry_reg <= in_carry;
        res_reg   <= in_res;
        for (int j = 0; j < LIMB_COUNT; j++)
        begin
            pp_reg[j][0] <= LIMB_W'(a_lo) * LIMB_W'(in_b[j*LIMB_W +: HALF_W]);
            pp_reg[j][1] <= LIMB_W'(a_lo) * LIMB_W'(in_b[j*LIMB_W+HALF_W +: HALF_W]);
            pp_reg[j][2] <= LIMB_W'(a_hi) * LIMB_W'(in_b[j*LIMB_W +: HALF_W]);
            pp_reg[j][3] <= LIMB_W'(a_hi) * LIMB_W'(in_b[j*LIMB_W+HALF_W +: HALF_W]);
        end
    end

    // Pack partial products of equal weight side by side; they do not overlap,
    // so the row is the sum of four wide terms
    always_comb
    begin
        for (int j = 0; j < LIMB_COUNT; j++)
        begin
            pp_ll[j*LIMB_W +: LIMB_W] = pp_reg[j][0];
            pp_lh[j*LIMB_W +: LIMB_W] = pp_reg[j][1];
            pp_hl[j*LIMB_W +: LIMB_W] = pp_reg[j][2];
            pp_hh[j*LIMB_W +: LIMB_W] = pp_reg[j][3];
        end
        row = ROW_W'(pp_ll)
            + (ROW_W'(pp_lh) << HALF_W)
            + (ROW_W'(pp_hl) << HALF_W)
            + (ROW_W'(pp_hh) << LIMB_W);
        acc_next = acc_reg + (PROD_W'(row) << (IDX*LIMB_W));
    end

    // Add or subtract this limb with the incoming carry or borrow
    always_comb
    begin
        limb_sum = {1'b0, a_reg[IDX*LIMB_W +: LIMB_W]}
                 + {1'b0, b_reg[IDX*LIMB_W +: LIMB_W]}
                 + (LIMB_W+1)'(carry_reg);
        limb_dif = {1'b0, a_reg[IDX*LIMB_W +: LIMB_W]}
                 - {1'b0, b_reg[IDX*LIMB_W +: LIMB_W]}
                 - (LIMB_W+1)'(carry_reg);
        res_next = res_reg;
        if (mode_reg == MODE_SUB)
        begin
            res_next[IDX*LIMB_W +: LIMB_W] = limb_dif[LIMB_W-1:0];
            carry_next = limb_dif[LIMB_W];
        end
        else
        begin
            res_next[IDX*LIMB_W +: LIMB_W] = limb_sum[LIMB_W-1:0];
            carry_next = limb_sum[LIMB_W];
        end
    end

    // Stage two: hold the updated word
    always_ff @(posedge clk)
    begin
        mode2_reg  <= mode_reg;
        a2_reg     <= a_reg;
        b2_reg     <= b_reg;
        acc2_reg   <= acc_next;
        carry2_reg <= carry_next;
        res2_reg   <= res_next;
    end

    assign out_valid = valid2_reg;
    assign out_mode  = mode2_reg;
    assign out_a     = a2_reg;
    assign out_b     = b2_reg;
    assign out_acc   = acc2_reg;
    assign out_carry = carry2_reg;
    assign out_res   = res2_reg;

endmodule
